// File: sv/multi_slot_write_deframer_core_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef MULTI_SLOT_WRITE_DEFRAMER_CORE_MACROS_SVH
`define MULTI_SLOT_WRITE_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MSWD_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MSWD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mswd_pkg.sv
// Types, codes and constants of the multi-slot write deframer.
`timescale 1ns / 1ps

package mswd_pkg;

  localparam int SLOTS_DEF         = 4;
  localparam int FRAME_PAYLOAD_DEF = 156;
  localparam int BUF_BYTES_DEF     = 256;
  localparam int OQ_DEPTH          = 8;

  localparam int RX_W  = 9;
  localparam int LEN_W = 10;

  localparam logic [7:0] HDR0_BYTE = 8'h0A;
  localparam logic [7:0] HDR1_BYTE = 8'hD0;
  localparam logic [7:0] TRL0_BYTE = 8'hDA;
  localparam logic [7:0] TRL1_BYTE = 8'h0D;

  localparam logic [RX_W-1:0] OPEN_PKT_BYTES = 9'd8;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_AUTH  = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_WAIT  = 2'd0,
    MODE_START = 2'd1,
    MODE_COLL  = 2'd2,
    MODE_FIN   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_DISCARD = 2'd2,
    KIND_REJECT  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [RX_W-1:0]  rx_count;
    mode_e            parse_mode;
    logic             authenticated;
    logic [LEN_W-1:0] bytes_left;
    logic             write_ignored;
  } slot_state_t;

  typedef struct packed {
    kind_e      kind;
    logic [1:0] slot;
    logic [7:0] payload;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

// File: sv/mswd_state_mem.sv
// Per-slot state memory: one write port, one registered read port, write-first bypass.
`timescale 1ns / 1ps

module mswd_state_mem #(
  parameter int DEPTH = 4,
  parameter int AW    = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  mswd_pkg::slot_state_t wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output mswd_pkg::slot_state_t rdata_o
);

  mswd_pkg::slot_state_t mem [DEPTH];
  mswd_pkg::slot_state_t rd_q;
  mswd_pkg::slot_state_t byp_data_q;
  logic [DEPTH-1:0]      vld_q;
  logic                  rvld_q;
  logic                  byp_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q       <= mem[raddr_i];
    byp_data_q <= wdata_i;
  end

  // Valid bits stand in for a clearing pass: an entry never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
      byp_q  <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
      byp_q  <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = byp_q ? byp_data_q : (rvld_q ? rd_q : '0);

endmodule

// File: sv/mswd_out_fifo.sv
// Result queue: up to two pushes and one pop per cycle.
`timescale 1ns / 1ps

module mswd_out_fifo #(
  parameter int DEPTH = mswd_pkg::OQ_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mswd_pkg::push_t    push_i,
  input  logic               pop_i,
  output logic               valid_o,
  output mswd_pkg::res_t     head_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mswd_pkg::res_t entries [DEPTH];
  logic [PW-1:0]  wr_q, wr_d, wr1, rd_q, rd_d;
  logic [CW-1:0]  count_q, count_d;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_comb begin
    wr1     = ptr_inc(wr_q);
    wr_d    = wr_q;
    rd_d    = pop_i ? ptr_inc(rd_q) : rd_q;
    count_d = count_q + CW'(push_i.cnt) - CW'(pop_i);
    case (push_i.cnt)
      2'd1:    wr_d = wr1;
      2'd2:    wr_d = ptr_inc(wr1);
      default: wr_d = wr_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      entries[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      entries[wr1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  assign valid_o = (count_q != '0);
  assign head_o  = entries[rd_q];
  assign count_o = count_q;

endmodule

// File: sv/multi_slot_write_deframer_core.sv
// Top level of the multi-slot write deframer: slot state pipeline and result queue.
// The accepted item is registered into stage 1; its results are pushed into the result queue
// at the end of stage 1 and offered from there. Throughput: one item per cycle while the
//   result queue has room; the read-modify-write of the slot state memory takes one stage,
//   and a same-slot item in the next cycle gets the new state through a bypass.
// Results leave at one per cycle when out_ready_i is high; two-result items drain at half rate.
// Reset: all slot state reads as zero at once through per-slot valid bits; no clearing pass.
`timescale 1ns / 1ps
`include "multi_slot_write_deframer_core_macros.svh"

module multi_slot_write_deframer_core #(
  parameter int SLOTS         = mswd_pkg::SLOTS_DEF,
  parameter int FRAME_PAYLOAD = mswd_pkg::FRAME_PAYLOAD_DEF,
  parameter int BUF_BYTES     = mswd_pkg::BUF_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input item channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] command_i,
  input  logic [1:0] slot_i,
  input  logic [7:0] data_byte_i,
  input  logic       first_of_write_i,
  input  logic [9:0] write_len_i,
  input  logic       auth_ok_i,
  // configuration: secure_mode
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  // result item channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [1:0] out_slot_o,
  output logic [7:0] payload_o,
  output logic       last_o
);

  // Only four slot codes can arrive, so the memory never needs more than four entries.
  localparam int MEM_DEPTH = (SLOTS < 4) ? SLOTS : 4;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int QD        = mswd_pkg::OQ_DEPTH;
  localparam int CW        = $clog2(QD + 1);
  localparam int RX_W      = mswd_pkg::RX_W;
  localparam int LEN_W     = mswd_pkg::LEN_W;

  localparam logic [RX_W-1:0]  FP_LIM  = RX_W'(FRAME_PAYLOAD);
  localparam logic [LEN_W:0]   BUF_LIM = (LEN_W + 1)'(BUF_BYTES);

  // Configuration register.
  logic secure_q;

  // Stage 1: the accepted item, while its slot state comes out of the memory.
  logic             s1_valid_q;
  logic [1:0]       s1_cmd_q;
  logic [1:0]       s1_slot_q;
  logic [7:0]       s1_byte_q;
  logic             s1_first_q;
  logic [LEN_W-1:0] s1_len_q;
  logic             s1_ok_q;

  logic in_acc;

  mswd_pkg::slot_state_t st, nx;
  logic                  mem_we;

  // Decoded conditions shared by the state update and the result logic.
  logic             in_range;
  logic [LEN_W-1:0] len1;
  logic [LEN_W-1:0] bl_next;
  logic [LEN_W:0]   fill_sum;
  logic [RX_W-1:0]  rx1;
  logic             reject;
  logic             ovf;
  logic             go;
  logic             pend_clr;
  logic             pend_ovf;
  logic             below_fp;

  mswd_pkg::push_t  push;
  mswd_pkg::res_t   head;
  logic [CW-1:0]    q_count;
  logic [1:0]       res_cnt;
  mswd_pkg::kind_e  k0, k1;
  logic [7:0]       p0;

  assign in_acc = in_valid_i && in_ready_o;

  // Accept only when the queue has room for this item and the one in stage 1.
  assign in_ready_o = ({1'b0, q_count} + (CW + 1)'(s1_valid_q ? 2 : 0)) <= (CW + 1)'(QD - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      secure_q   <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        secure_q <= cfg_wdata_i;
      end
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q   <= command_i;
      s1_slot_q  <= slot_i;
      s1_byte_q  <= data_byte_i;
      s1_first_q <= first_of_write_i;
      s1_len_q   <= write_len_i;
      s1_ok_q    <= auth_ok_i;
    end
  end

  // Read at the accept edge; write back at the end of stage 1.
  mswd_state_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (AW)
  ) u_state_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (s1_slot_q[AW-1:0]),
    .wdata_i (nx),
    .raddr_i (slot_i[AW-1:0]),
    .rdata_o (st)
  );

  always_comb begin
    in_range = ({30'd0, s1_slot_q} < SLOTS);
    len1     = (s1_len_q == '0) ? LEN_W'(1) : s1_len_q;
    fill_sum = {2'b00, st.rx_count} + {1'b0, len1};
    rx1      = st.rx_count + RX_W'(1);
    reject   = secure_q && !st.authenticated;
    ovf      = fill_sum > BUF_LIM;
    below_fp = st.rx_count < FP_LIM;
    // Payload already streamed without a closing marker.
    pend_ovf = secure_q ? ((st.parse_mode == mswd_pkg::MODE_COLL) && (st.rx_count != '0))
                        : (st.rx_count != '0);
    pend_clr = secure_q ? (((st.parse_mode == mswd_pkg::MODE_COLL) && (st.rx_count != '0))
                           || (st.parse_mode == mswd_pkg::MODE_FIN))
                        : (st.rx_count != '0);
    if (s1_first_q) begin
      bl_next = len1 - LEN_W'(1);
      go      = !reject && !ovf;
    end else begin
      bl_next = (st.bytes_left != '0) ? st.bytes_left - LEN_W'(1) : st.bytes_left;
      go      = (st.bytes_left != '0) && !st.write_ignored;
    end
  end

  assign mem_we = s1_valid_q && in_range;

  // Next slot state.
  always_comb begin
    nx = st;
    case (s1_cmd_q)
      mswd_pkg::CMD_CLEAR: begin
        nx = '0;
      end
      mswd_pkg::CMD_AUTH: begin
        nx.authenticated = s1_ok_q;
      end
      mswd_pkg::CMD_DATA: begin
        nx.bytes_left = bl_next;
        if (s1_first_q) begin
          if (reject) begin
            nx.write_ignored = 1'b1;
          end else if (ovf) begin
            nx.rx_count      = '0;
            nx.write_ignored = 1'b1;
          end else begin
            nx.write_ignored = 1'b0;
          end
        end
        if (go) begin
          if (!secure_q) begin
            // Close the packet on the last byte of a write once eight or more have gathered.
            nx.rx_count = ((bl_next == '0) && (rx1 >= mswd_pkg::OPEN_PKT_BYTES)) ? '0 : rx1;
          end else begin
            case (st.parse_mode)
              mswd_pkg::MODE_WAIT: begin
                if (s1_byte_q == mswd_pkg::HDR0_BYTE) begin
                  nx.parse_mode = mswd_pkg::MODE_START;
                end
              end
              mswd_pkg::MODE_START: begin
                nx.parse_mode = (s1_byte_q == mswd_pkg::HDR1_BYTE) ? mswd_pkg::MODE_COLL
                                                                   : mswd_pkg::MODE_WAIT;
                nx.rx_count   = '0;
              end
              mswd_pkg::MODE_COLL: begin
                if (below_fp) begin
                  nx.rx_count = rx1;
                end else if (s1_byte_q == mswd_pkg::TRL0_BYTE) begin
                  nx.rx_count   = rx1;
                  nx.parse_mode = mswd_pkg::MODE_FIN;
                end else begin
                  nx.parse_mode = mswd_pkg::MODE_WAIT;
                end
              end
              default: begin
                if (s1_byte_q == mswd_pkg::TRL1_BYTE) begin
                  nx.rx_count = '0;
                end
                nx.parse_mode = mswd_pkg::MODE_WAIT;
              end
            endcase
          end
        end
      end
      default: begin
        nx = st;
      end
    endcase
  end

  // Results of the item in stage 1.
  always_comb begin
    res_cnt = 2'd0;
    k0      = mswd_pkg::KIND_PAYLOAD;
    k1      = mswd_pkg::KIND_PAYLOAD;
    p0      = '0;
    case (s1_cmd_q)
      mswd_pkg::CMD_CLEAR: begin
        if (pend_clr) begin
          res_cnt = 2'd1;
          k0      = mswd_pkg::KIND_DISCARD;
        end
      end
      mswd_pkg::CMD_DATA: begin
        if (s1_first_q && reject) begin
          res_cnt = 2'd1;
          k0      = mswd_pkg::KIND_REJECT;
        end else if (s1_first_q && ovf) begin
          if (pend_ovf) begin
            res_cnt = 2'd1;
            k0      = mswd_pkg::KIND_DISCARD;
          end
        end else if (go) begin
          if (!secure_q) begin
            res_cnt = 2'd1;
            p0      = s1_byte_q;
            if (bl_next == '0) begin
              if (rx1 == mswd_pkg::OPEN_PKT_BYTES) begin
                res_cnt = 2'd2;
                k1      = mswd_pkg::KIND_ACCEPT;
              end else if (rx1 > mswd_pkg::OPEN_PKT_BYTES) begin
                res_cnt = 2'd2;
                k1      = mswd_pkg::KIND_DISCARD;
              end
            end
          end else begin
            case (st.parse_mode)
              mswd_pkg::MODE_COLL: begin
                if (below_fp) begin
                  res_cnt = 2'd1;
                  p0      = s1_byte_q;
                end else if (s1_byte_q != mswd_pkg::TRL0_BYTE) begin
                  res_cnt = 2'd1;
                  k0      = mswd_pkg::KIND_DISCARD;
                end
              end
              mswd_pkg::MODE_FIN: begin
                res_cnt = 2'd1;
                k0      = (s1_byte_q == mswd_pkg::TRL1_BYTE) ? mswd_pkg::KIND_ACCEPT
                                                             : mswd_pkg::KIND_DISCARD;
              end
              default: begin
                res_cnt = 2'd0;
              end
            endcase
          end
        end
      end
      default: begin
        res_cnt = 2'd0;
      end
    endcase

    push.cnt        = mem_we ? res_cnt : 2'd0;
    push.r0.kind    = k0;
    push.r0.slot    = s1_slot_q;
    push.r0.payload = p0;
    push.r0.last    = (res_cnt == 2'd1);
    push.r1.kind    = k1;
    push.r1.slot    = s1_slot_q;
    push.r1.payload = '0;
    push.r1.last    = 1'b1;
  end

  mswd_out_fifo #(
    .DEPTH (QD)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_valid_o && out_ready_i),
    .valid_o (out_valid_o),
    .head_o  (head),
    .count_o (q_count)
  );

  assign kind_o     = head.kind;
  assign out_slot_o = head.slot;
  assign payload_o  = head.payload;
  assign last_o     = head.last;

  `MSWD_ASSERT_NEXT(a_accept_enters_s1, in_acc, s1_valid_q, "accepted item missing from stage 1")
  `MSWD_ASSERT(a_queue_room, s1_valid_q, ({1'b0, q_count} + (CW + 1)'(push.cnt)) <= (CW + 1)'(QD), "result queue overflow")
  `MSWD_ASSERT(a_marker_no_payload, out_valid_o && (kind_o != mswd_pkg::KIND_PAYLOAD), payload_o == 8'd0, "marker carries payload")
  `MSWD_ASSERT(a_push_in_range, push.cnt != 2'd0, s1_valid_q && in_range, "results from an ignored item")

endmodule

// File: tb/multi_slot_write_deframer_core_tb.sv
// Self-checking testbench for the multi-slot write deframer core.
`timescale 1ns / 1ps

module multi_slot_write_deframer_core_tb;

  localparam int         NSLOT       = mswd_pkg::SLOTS_DEF;
  localparam int         LEN_W       = mswd_pkg::LEN_W;
  localparam int         ITEM_GOAL   = 1900;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         DRAIN_GAP   = 8;
  localparam int         HOLD_CYCLES = 300;
  localparam logic [1:0] CMD_UNUSED  = 2'd3;

  // One input item as it crosses the input handshake.
  typedef struct packed {
    logic [1:0]       cmd;
    logic [1:0]       slot;
    logic [7:0]       data;
    logic             first;
    logic [LEN_W-1:0] len;
    logic             auth;
  } rx_item_t;

  logic             clk_i            = 1'b0;
  logic             rst_ni           = 1'b0;
  logic             in_valid_i       = 1'b0;
  logic             in_ready_o;
  logic [1:0]       command_i        = '0;
  logic [1:0]       slot_i           = '0;
  logic [7:0]       data_byte_i      = '0;
  logic             first_of_write_i = 1'b0;
  logic [9:0]       write_len_i      = '0;
  logic             auth_ok_i        = 1'b0;
  logic             cfg_we_i         = 1'b0;
  logic             cfg_wdata_i      = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i      = 1'b0;
  logic [1:0]       kind_o;
  logic [1:0]       out_slot_o;
  logic [7:0]       payload_o;
  logic             last_o;

  // Stimulus: per-slot streams are built first, then merged into the send queue.
  rx_item_t    lane_q[NSLOT][$];
  rx_item_t    pending_items[$];
  logic [7:0]  wr_bytes[$];
  logic [7:0]  frame_bytes[$];
  int          n_queued   = 0;
  int          n_accepted = 0;
  int          n_phases   = 0;

  // Prediction: per-slot deframer state, the mode bit, and the results still due.
  mswd_pkg::slot_state_t slot_st[NSLOT];
  logic                  secure_cfg = 1'b0;
  mswd_pkg::res_t        step_res[$];
  mswd_pkg::res_t        due_results[$];

  // Driver, receiver and bookkeeping state.
  rx_item_t       cur_item;
  logic           nxt_valid;
  int             burst_left  = 0;
  int             gap_left    = 0;
  int             stall_style = 0;
  int             style_left  = 0;
  int             pat_cnt     = 0;
  logic           pat_ready;
  int             hold_left   = 0;
  int             hold_done   = 0;
  int             cyc_cnt     = 0;
  int             n_errors    = 0;
  int             n_checked   = 0;
  int             kind_cnt[4] = '{0, 0, 0, 0};
  mswd_pkg::res_t want_res;

  multi_slot_write_deframer_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .command_i        (command_i),
    .slot_i           (slot_i),
    .data_byte_i      (data_byte_i),
    .first_of_write_i (first_of_write_i),
    .write_len_i      (write_len_i),
    .auth_ok_i        (auth_ok_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .out_slot_o       (out_slot_o),
    .payload_o        (payload_o),
    .last_o           (last_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void note_result(input mswd_pkg::kind_e k, input logic [1:0] s,
                                      input logic [7:0] p);
    mswd_pkg::res_t r;
    r.kind    = k;
    r.slot    = s;
    r.payload = p;
    r.last    = 1'b0;
    step_res.push_back(r);
  endfunction

  // Advance one slot by one item and collect its results in step_res.
  function automatic void deframe_step(input rx_item_t it);
    logic [1:0] s;
    int         len;
    logic       pend;
    s = it.slot;
    if (it.cmd == mswd_pkg::CMD_CLEAR) begin
      // Streamed bytes without a closing marker get a discard before the wipe.
      pend = secure_cfg ?
             ((slot_st[s].parse_mode == mswd_pkg::MODE_COLL && slot_st[s].rx_count != 0) ||
              slot_st[s].parse_mode == mswd_pkg::MODE_FIN) :
             (slot_st[s].rx_count != 0);
      if (pend) note_result(mswd_pkg::KIND_DISCARD, s, 8'h00);
      slot_st[s] = '0;
      return;
    end
    if (it.cmd == mswd_pkg::CMD_AUTH) begin
      slot_st[s].authenticated = it.auth;
      return;
    end
    if (it.cmd != mswd_pkg::CMD_DATA) return;

    if (it.first) begin
      len = (it.len == 0) ? 1 : int'(it.len);
      slot_st[s].bytes_left = LEN_W'(len - 1);
      if (secure_cfg && !slot_st[s].authenticated) begin
        slot_st[s].write_ignored = 1'b1;
        note_result(mswd_pkg::KIND_REJECT, s, 8'h00);
        return;
      end
      if (int'(slot_st[s].rx_count) + len > mswd_pkg::BUF_BYTES_DEF) begin
        // Too long for the buffer: drop the whole write and start the count over.
        pend = secure_cfg ?
               (slot_st[s].parse_mode == mswd_pkg::MODE_COLL && slot_st[s].rx_count != 0) :
               (slot_st[s].rx_count != 0);
        if (pend) note_result(mswd_pkg::KIND_DISCARD, s, 8'h00);
        slot_st[s].rx_count      = '0;
        slot_st[s].write_ignored = 1'b1;
        return;
      end
      slot_st[s].write_ignored = 1'b0;
    end else begin
      if (slot_st[s].bytes_left == 0) return;
      slot_st[s].bytes_left = slot_st[s].bytes_left - 1'b1;
      if (slot_st[s].write_ignored) return;
    end

    if (!secure_cfg) begin
      // Open mode: packets close only on a write boundary.
      note_result(mswd_pkg::KIND_PAYLOAD, s, it.data);
      slot_st[s].rx_count = slot_st[s].rx_count + 1'b1;
      if (slot_st[s].bytes_left == 0) begin
        if (slot_st[s].rx_count == mswd_pkg::OPEN_PKT_BYTES) begin
          note_result(mswd_pkg::KIND_ACCEPT, s, 8'h00);
          slot_st[s].rx_count = '0;
        end else if (slot_st[s].rx_count > mswd_pkg::OPEN_PKT_BYTES) begin
          note_result(mswd_pkg::KIND_DISCARD, s, 8'h00);
          slot_st[s].rx_count = '0;
        end
      end
      return;
    end

    case (slot_st[s].parse_mode)
      mswd_pkg::MODE_WAIT: begin
        if (it.data == mswd_pkg::HDR0_BYTE) slot_st[s].parse_mode = mswd_pkg::MODE_START;
      end
      mswd_pkg::MODE_START: begin
        slot_st[s].parse_mode = (it.data == mswd_pkg::HDR1_BYTE) ? mswd_pkg::MODE_COLL
                                                                 : mswd_pkg::MODE_WAIT;
        slot_st[s].rx_count   = '0;
      end
      mswd_pkg::MODE_COLL: begin
        if (int'(slot_st[s].rx_count) < mswd_pkg::FRAME_PAYLOAD_DEF) begin
          note_result(mswd_pkg::KIND_PAYLOAD, s, it.data);
          slot_st[s].rx_count = slot_st[s].rx_count + 1'b1;
        end else if (it.data == mswd_pkg::TRL0_BYTE) begin
          slot_st[s].rx_count   = slot_st[s].rx_count + 1'b1;
          slot_st[s].parse_mode = mswd_pkg::MODE_FIN;
        end else begin
          note_result(mswd_pkg::KIND_DISCARD, s, 8'h00);
          slot_st[s].parse_mode = mswd_pkg::MODE_WAIT;
        end
      end
      default: begin
        if (it.data == mswd_pkg::TRL1_BYTE) begin
          note_result(mswd_pkg::KIND_ACCEPT, s, 8'h00);
          slot_st[s].rx_count = '0;
        end else begin
          note_result(mswd_pkg::KIND_DISCARD, s, 8'h00);
        end
        slot_st[s].parse_mode = mswd_pkg::MODE_WAIT;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: bursts of items from the send queue with random gaps in between
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        // Item taken: predict its results; the last one carries the last flag.
        step_res.delete();
        deframe_step(cur_item);
        if (step_res.size() != 0) step_res[step_res.size() - 1].last = 1'b1;
        foreach (step_res[i]) due_results.push_back(step_res[i]);
        n_accepted++;
      end
      // Hold valid and payload until the item is taken.
      if (!(in_valid_i && !in_ready_o)) begin
        nxt_valid = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_items.size() != 0) begin
          cur_item         = pending_items.pop_front();
          nxt_valid        = 1'b1;
          command_i        <= cur_item.cmd;
          slot_i           <= cur_item.slot;
          data_byte_i      <= cur_item.data;
          first_of_write_i <= cur_item.first;
          write_len_i      <= cur_item.len;
          auth_ok_i        <= cur_item.auth;
          if (burst_left == 0) begin
            // End of burst: pick the next burst and, mostly, a gap before it.
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
        in_valid_i <= nxt_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver hold-off: lets the result queue fill and back-pressure the input
  // ---------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ((hold_done == 0 && n_accepted >= 500) ||
                 (hold_done == 1 && n_accepted >= 1300)) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_done + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result against the oldest one due, then pick next ready
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string what, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (due_results.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, expected none, got kind %0d slot %0d",
                   $time, kind_o, out_slot_o);
        end else begin
          want_res = due_results.pop_front();
          check_field("kind", 8'(want_res.kind), 8'(kind_o));
          check_field("slot", 8'(want_res.slot), 8'(out_slot_o));
          check_field("payload", want_res.payload, payload_o);
          check_field("last", 8'(want_res.last), 8'(last_o));
          n_checked++;
          kind_cnt[want_res.kind]++;
        end
      end
      // Switch between stall styles now and then; styles 0 to 2 never stall outside a hold-off.
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 9);
        style_left  = $urandom_range(20, 200);
      end else begin
        style_left--;
      end
      pat_cnt++;
      if (stall_style < 3)      pat_ready = 1'b1;
      else if (stall_style < 6) pat_ready = 1'($urandom_range(0, 1));
      else if (stall_style < 8) pat_ready = ($urandom_range(0, 3) == 0);
      else                      pat_ready = (pat_cnt % 5 != 4);
      out_ready_i <= pat_ready && (hold_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic rx_item_t mk_item(input logic [1:0] cmd, input int s,
                                       input logic [7:0] data, input logic first,
                                       input int len, input logic auth);
    rx_item_t it;
    it.cmd   = cmd;
    it.slot  = 2'(s);
    it.data  = data;
    it.first = first;
    it.len   = LEN_W'(len);
    it.auth  = auth;
    return it;
  endfunction

  // Side fields that the command does not use are random.
  function automatic rx_item_t mk_cmd(input logic [1:0] cmd, input int s,
                                      input logic auth);
    return mk_item(cmd, s, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   $urandom_range(1, 512), auth);
  endfunction

  function automatic void fill_random(input int n);
    repeat (n) wr_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Turn wr_bytes into one write on a slot; the length rides on the first byte.
  function automatic void lane_write(input int s, input int len_field);
    foreach (wr_bytes[i])
      lane_q[s].push_back(mk_item(mswd_pkg::CMD_DATA, s, wr_bytes[i], i == 0,
                                  (i == 0) ? len_field : $urandom_range(1, 512),
                                  1'($urandom_range(0, 1))));
    wr_bytes.delete();
  endfunction

  // Interleave the slot streams in short runs, with an unused command now and then.
  function automatic void merge_lanes();
    int s;
    int run;
    int left;
    forever begin
      left = 0;
      for (int i = 0; i < NSLOT; i++) left += lane_q[i].size();
      if (left == 0) break;
      s   = $urandom_range(0, NSLOT - 1);
      run = $urandom_range(1, 8);
      while (run != 0 && lane_q[s].size() != 0) begin
        pending_items.push_back(lane_q[s].pop_front());
        n_queued++;
        run--;
      end
      if ($urandom_range(0, 49) == 0) begin
        pending_items.push_back(mk_cmd(CMD_UNUSED, $urandom_range(0, NSLOT - 1),
                                       1'($urandom_range(0, 1))));
        n_queued++;
      end
    end
  endfunction

  function automatic void gen_open_lane(input int s);
    int sel;
    int left;
    int n;
    repeat ($urandom_range(4, 8)) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        // clean packet, split over one or more writes
        left = mswd_pkg::OPEN_PKT_BYTES;
        while (left != 0) begin
          n = $urandom_range(1, left);
          fill_random(n);
          lane_write(s, (n == 1 && $urandom_range(0, 2) == 0) ? 0 : n);
          left -= n;
        end
      end else if (sel < 67) begin
        // write that overshoots the packet size
        n = $urandom_range(9, 24);
        fill_random(n);
        lane_write(s, n);
      end else if (sel < 74) begin
        // long write cut short: leaves a large count for the next write
        n = $urandom_range(40, 160);
        fill_random($urandom_range(n / 2, n - 1));
        lane_write(s, n);
      end else if (sel < 80) begin
        // write too long for the buffer
        fill_random($urandom_range(1, 3));
        lane_write(s, $urandom_range(mswd_pkg::BUF_BYTES_DEF + 1, 512));
      end else if (sel < 86) begin
        // stray bytes past the end of a write
        n = $urandom_range(1, 7);
        fill_random(n + $urandom_range(1, 3));
        lane_write(s, n);
      end else if (sel < 92) begin
        lane_q[s].push_back(mk_cmd(mswd_pkg::CMD_CLEAR, s, 1'($urandom_range(0, 1))));
      end else if (sel < 97) begin
        lane_q[s].push_back(mk_cmd(mswd_pkg::CMD_AUTH, s, 1'($urandom_range(0, 1))));
      end else begin
        lane_q[s].push_back(mk_cmd(CMD_UNUSED, s, 1'($urandom_range(0, 1))));
      end
    end
  endfunction

  function automatic void gen_secure_lane(input int s);
    int         flaw;
    int         n;
    logic [7:0] junk;
    logic       cut_done;
    lane_q[s].push_back(mk_cmd(mswd_pkg::CMD_AUTH, s, $urandom_range(0, 7) != 0));
    repeat ($urandom_range(0, 1)) begin
      // flaw: 0-6 clean, 7/8 bad header, 9/10 bad trailer,
      // 11 stop after the first trailer byte and clear, 12 clear mid-payload
      flaw = $urandom_range(0, 12);
      repeat ($urandom_range(0, 3)) begin
        junk = 8'($urandom_range(0, 255));
        frame_bytes.push_back((junk == mswd_pkg::HDR0_BYTE) ? 8'h0B : junk);
      end
      frame_bytes.push_back((flaw == 7) ? mswd_pkg::HDR0_BYTE ^ 8'($urandom_range(1, 255))
                                        : mswd_pkg::HDR0_BYTE);
      frame_bytes.push_back((flaw == 8) ? mswd_pkg::HDR1_BYTE ^ 8'($urandom_range(1, 255))
                                        : mswd_pkg::HDR1_BYTE);
      repeat (mswd_pkg::FRAME_PAYLOAD_DEF) frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back((flaw == 9) ? mswd_pkg::TRL0_BYTE ^ 8'($urandom_range(1, 255))
                                        : mswd_pkg::TRL0_BYTE);
      if (flaw != 11)
        frame_bytes.push_back((flaw == 10) ? mswd_pkg::TRL1_BYTE ^ 8'($urandom_range(1, 255))
                                           : mswd_pkg::TRL1_BYTE);
      if (flaw != 12 && $urandom_range(0, 2) == 0) begin
        wr_bytes = frame_bytes;
        lane_write(s, wr_bytes.size());
      end else begin
        cut_done = 1'b0;
        while (frame_bytes.size() != 0) begin
          n = (flaw == 12 && !cut_done) ? $urandom_range(10, 64) : $urandom_range(1, 64);
          if (n > frame_bytes.size()) n = frame_bytes.size();
          repeat (n) wr_bytes.push_back(frame_bytes.pop_front());
          lane_write(s, n);
          if (flaw == 12 && !cut_done) begin
            lane_q[s].push_back(mk_cmd(mswd_pkg::CMD_CLEAR, s, 1'($urandom_range(0, 1))));
            cut_done = 1'b1;
          end
        end
      end
      frame_bytes.delete();
      if (flaw == 11)
        lane_q[s].push_back(mk_cmd(mswd_pkg::CMD_CLEAR, s, 1'($urandom_range(0, 1))));
    end
  endfunction

  // Block is idle once every item is taken and every result has come back;
  // then allow for items that are still in flight but make no result.
  task automatic wait_drained();
    while (n_accepted != n_queued || due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic set_secure(input logic v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    secure_cfg  = v;
  endtask

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------

  initial begin
    wait (cyc_cnt >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still due", cyc_cnt, due_results.size());
    $display("multi_slot_write_deframer_core verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int i = 0; i < NSLOT; i++) slot_st[i] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, open mode.
    // slot 0: unused command, clear with nothing pending, then half a write
    lane_q[0].push_back(mk_item(CMD_UNUSED, 0, 8'hFF, 1'b1, 512, 1'b1));
    lane_q[0].push_back(mk_cmd(mswd_pkg::CMD_CLEAR, 0, 1'b0));
    wr_bytes = '{mswd_pkg::HDR0_BYTE, mswd_pkg::HDR1_BYTE};
    lane_write(0, 4);
    // slot 1: exact packet of extreme bytes
    wr_bytes = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h01, 8'h80};
    lane_write(1, 8);
    // slot 2: zero length taken as one, then an overflow with a byte pending
    wr_bytes = '{8'hA5};
    lane_write(2, 0);
    wr_bytes = '{8'h3C};
    lane_write(2, 300);
    // slot 3: stray byte, then the longest write, which overflows
    lane_q[3].push_back(mk_item(mswd_pkg::CMD_DATA, 3, 8'h11, 1'b0, 5, 1'b0));
    wr_bytes = '{8'h77, 8'h88};
    lane_write(3, 512);
    merge_lanes();
    wait_drained();
    n_phases++;

    // Directed, secure mode; slot 0 finishes its write under the new mode.
    set_secure(1'b1);
    lane_q[0].push_back(mk_item(mswd_pkg::CMD_DATA, 0, mswd_pkg::HDR0_BYTE, 1'b0, 1, 1'b0));
    lane_q[0].push_back(mk_item(mswd_pkg::CMD_DATA, 0, mswd_pkg::HDR1_BYTE, 1'b0, 1, 1'b0));
    wr_bytes = '{8'h5A};
    lane_write(0, 3);
    lane_q[0].push_back(mk_item(mswd_pkg::CMD_AUTH, 0, 8'h00, 1'b0, 1, 1'b1));
    wr_bytes = '{mswd_pkg::HDR0_BYTE, mswd_pkg::HDR1_BYTE, 8'h33, 8'h44};
    lane_write(0, 4);
    lane_q[0].push_back(mk_cmd(mswd_pkg::CMD_CLEAR, 0, 1'b1));
    lane_q[1].push_back(mk_item(mswd_pkg::CMD_AUTH, 1, 8'hFF, 1'b1, 1, 1'b0));
    wr_bytes = '{8'hC3};
    lane_write(1, 1);
    merge_lanes();
    wait_drained();
    n_phases++;

    // Random phases, alternating open and secure mode.
    while (n_queued < ITEM_GOAL) begin
      set_secure(n_phases % 2 == 1);
      for (int s = 0; s < NSLOT; s++) begin
        if (secure_cfg) gen_secure_lane(s);
        else gen_open_lane(s);
      end
      merge_lanes();
      wait_drained();
      n_phases++;
    end

    $display("covered %0d items over %0d mode phases, %0d results checked",
             n_accepted, n_phases, n_checked);
    $display("results: %0d payload, %0d accept, %0d discard, %0d reject",
             kind_cnt[mswd_pkg::KIND_PAYLOAD], kind_cnt[mswd_pkg::KIND_ACCEPT],
             kind_cnt[mswd_pkg::KIND_DISCARD], kind_cnt[mswd_pkg::KIND_REJECT]);
    if (n_errors == 0) begin
      $display("multi_slot_write_deframer_core verification clean");
    end else begin
      $display("multi_slot_write_deframer_core verification failed");
    end
    $finish;
  end

endmodule
